>>> hdl/ski_pkg.sv
// ----------------------------------------------------------------------------
// ski_pkg
// Shared types, constants and joint tables of the servo keyframe interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ski_pkg;

	localparam int JOINT_COUNT = 6;

	localparam int ANGLE_W    = 9;
	localparam int STEP_W     = 8;
	localparam int PULSE_W    = 12;
	localparam int PRODUCT_W  = ANGLE_W + STEP_W;
	localparam int DIVIDEND_W = 20;
	localparam int DIVISOR_W  = 9;

	localparam int PULSE_MIN  = 500;
	localparam int PULSE_SPAN = 2000;
	localparam int BASE_RANGE = 270;
	localparam int STD_RANGE  = 180;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic REG_SEGMENT_STEPS  = 1'b0;
	localparam logic REG_KEYFRAME_COUNT = 1'b1;

	localparam logic [2:0] JOINT_GRIPPER  = 3'd0;
	localparam logic [2:0] JOINT_BASE     = 3'd1;
	localparam logic [2:0] JOINT_SHOULDER = 3'd2;
	localparam logic [2:0] JOINT_ELBOW    = 3'd3;
	localparam logic [2:0] JOINT_PITCH    = 3'd4;
	localparam logic [2:0] JOINT_ROLL     = 3'd5;

	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [2:0] joint_t;
	typedef logic [JOINT_COUNT-1:0][PULSE_W-1:0] pulse_set_t;

	typedef struct packed {
		logic start;
		logic res_take;
	} eng_ctrl_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} eng_stat_t;

	function automatic angle_t joint_lo(input joint_t j);
		angle_t lo;
		case (j) inside
			JOINT_GRIPPER: lo = angle_t'(0);
			JOINT_SHOULDER, JOINT_ELBOW: lo = angle_t'(20);
			JOINT_BASE, JOINT_PITCH, JOINT_ROLL: lo = angle_t'(10);
			default: lo = angle_t'(10);
		endcase
		return lo;
	endfunction

	function automatic angle_t joint_hi(input joint_t j);
		angle_t hi;
		case (j) inside
			JOINT_GRIPPER: hi = angle_t'(180);
			JOINT_BASE: hi = angle_t'(260);
			JOINT_SHOULDER, JOINT_ELBOW: hi = angle_t'(160);
			JOINT_PITCH, JOINT_ROLL: hi = angle_t'(170);
			default: hi = angle_t'(170);
		endcase
		return hi;
	endfunction

	function automatic logic [DIVISOR_W-1:0] joint_range(input joint_t j);
		logic [DIVISOR_W-1:0] r;
		case (j)
			JOINT_BASE: r = DIVISOR_W'(BASE_RANGE);
			default: r = DIVISOR_W'(STD_RANGE);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/servo_keyframe_interpolator_core.sv
// ----------------------------------------------------------------------------
// servo_keyframe_interpolator_core
// Six-joint keyframe sequencer with linear interpolation and pulse mapping.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall): a load writes one joint angle of one
//   keyframe, a start begins a run when idle, a tick emits the next pose of
//   the run. Loads, starts and ignored ticks give nothing.
//   result channel (result_valid/result_stall): one transaction per tick while
//   running, six pulse widths in microseconds, the segment number and run_done
//   on the final point. An output register holds the result, so new items
//   are taken while it waits.
//   Per joint a tick does two table reads, a shift-add multiply and two passes
//   of the one shared serial divider (interpolation, then pulse scaling), six
//   joints in turn. item_stall stays high from the tick transaction until its
//   pose has moved into the output register; if the receiver stalls, the next
//   pose waits. The APB port writes segment_steps (0x0) and keyframe_count
//   (0x4); the user writes them only while the block is idle, which the block
//   does not enforce. Reset stops any run and restores the register defaults;
//   keyframe entries must be loaded before a run reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_keyframe_interpolator_core #(
	parameter int MAX_KEYFRAMES = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  frame_index,
	input  logic [2:0]  joint_index,
	input  logic [8:0]  angle_value,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [11:0] gripper_pulse,
	output logic [11:0] base_pulse,
	output logic [11:0] shoulder_pulse,
	output logic [11:0] elbow_pulse,
	output logic [11:0] pitch_pulse,
	output logic [11:0] roll_pulse,
	output logic [2:0]  segment_number,
	output logic        run_done
);

	localparam int DEPTH  = MAX_KEYFRAMES * ski_pkg::JOINT_COUNT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SEG_W  = (MAX_KEYFRAMES > 2) ? $clog2(MAX_KEYFRAMES - 1) : 1;
	localparam int CMP_W  = $clog2(MAX_KEYFRAMES + 16);
	localparam int STEP_W = ski_pkg::STEP_W;

	logic [STEP_W-1:0]    segment_steps_q;
	logic [3:0]           keyframe_count_q;
	logic                 running_q;
	logic [SEG_W-1:0]     seg_q;
	logic [STEP_W-1:0]    step_q;
	logic [2:0]           seg_pend_q;
	logic                 last_pend_q;
	logic                 result_valid_q;
	ski_pkg::pulse_set_t  pulse_out_q;
	logic [2:0]           seg_out_q;
	logic                 done_out_q;

	logic                 cfg_write;
	logic                 item_acc;
	logic                 tick_go;
	logic                 start_go;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;
	ski_pkg::angle_t      rd_data;
	logic [STEP_W-1:0]    steps_eff;
	logic [STEP_W-1:0]    step_eff;
	logic [CMP_W-1:0]     kc_ext;
	logic [CMP_W-1:0]     count_eff;
	logic                 end_c;
	logic                 last_c;
	ski_pkg::eng_ctrl_t   eng_ctrl;
	ski_pkg::eng_stat_t   eng_stat;
	ski_pkg::pulse_set_t  eng_pulses;

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_steps_q  <= STEP_W'(60);
			keyframe_count_q <= 4'd6;
		end else if (cfg_write) begin
			unique case (paddr[2])
				ski_pkg::REG_SEGMENT_STEPS: segment_steps_q <= pwdata[STEP_W-1:0];
				ski_pkg::REG_KEYFRAME_COUNT: keyframe_count_q <= pwdata[3:0];
				default: segment_steps_q <= segment_steps_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ski_pkg::REG_SEGMENT_STEPS: prdata = 32'(segment_steps_q);
			ski_pkg::REG_KEYFRAME_COUNT: prdata = 32'(keyframe_count_q);
			default: prdata = '0;
		endcase
	end

	// item decode
	assign item_stall = eng_stat.busy;
	assign item_acc   = item_valid && !item_stall;
	assign tick_go    = item_acc && (opcode == ski_pkg::OP_TICK) && running_q;
	assign start_go   = item_acc && (opcode == ski_pkg::OP_START) && !running_q;

	assign wr_en = item_acc && (opcode == ski_pkg::OP_LOAD)
		&& (int'(frame_index) < MAX_KEYFRAMES)
		&& (int'(joint_index) < ski_pkg::JOINT_COUNT);
	assign wr_addr = ADDR_W'(frame_index) * ADDR_W'(ski_pkg::JOINT_COUNT)
		+ ADDR_W'(joint_index);

	// effective step count and keyframe count for this tick
	assign steps_eff = (segment_steps_q == '0) ? STEP_W'(1) : segment_steps_q;
	assign step_eff  = (step_q > steps_eff) ? steps_eff : step_q;
	assign kc_ext    = CMP_W'(keyframe_count_q);

	always_comb begin
		if (kc_ext < CMP_W'(2)) begin
			count_eff = CMP_W'(2);
		end else if (kc_ext > CMP_W'(MAX_KEYFRAMES)) begin
			count_eff = CMP_W'(MAX_KEYFRAMES);
		end else begin
			count_eff = kc_ext;
		end
	end

	assign end_c  = step_q >= steps_eff;
	assign last_c = (CMP_W'(seg_q) + CMP_W'(2)) >= count_eff;

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			seg_q     <= '0;
			step_q    <= '0;
		end else if (tick_go) begin
			if (end_c) begin
				step_q <= '0;
				if (last_c) begin
					running_q <= 1'b0;
					seg_q     <= '0;
				end else begin
					seg_q <= seg_q + SEG_W'(1);
				end
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end else if (start_go) begin
			running_q <= 1'b1;
			seg_q     <= '0;
			step_q    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			seg_pend_q  <= 3'(seg_q);
			last_pend_q <= end_c && last_c;
		end
	end

	ski_ram #(
		.WIDTH(ski_pkg::ANGLE_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(angle_value),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign eng_ctrl.start    = tick_go;
	assign eng_ctrl.res_take = eng_stat.res_valid && (!result_valid_q || !result_stall);

	ski_pose_engine #(
		.MAX_KEYFRAMES(MAX_KEYFRAMES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (eng_ctrl),
		.seg      (seg_q),
		.step     (step_eff),
		.steps    (steps_eff),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.stat     (eng_stat),
		.pulse_set(eng_pulses)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eng_ctrl.res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_ctrl.res_take) begin
			pulse_out_q <= eng_pulses;
			seg_out_q   <= seg_pend_q;
			done_out_q  <= last_pend_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign gripper_pulse  = pulse_out_q[0];
	assign base_pulse     = pulse_out_q[1];
	assign shoulder_pulse = pulse_out_q[2];
	assign elbow_pulse    = pulse_out_q[3];
	assign pitch_pulse    = pulse_out_q[4];
	assign roll_pulse     = pulse_out_q[5];
	assign segment_number = seg_out_q;
	assign run_done       = done_out_q;

	// a tick taken during a run always launches the pose engine
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> eng_stat.busy)
		else $error("tick transaction did not start the pose engine");

	// a run only ends on a point flagged as final
	a_run_end_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> last_pend_q)
		else $error("run ended without a final point");

	// between runs the position counters sit at zero
	a_idle_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (seg_q == '0 && step_q == '0))
		else $error("segment or step index not cleared while idle");

	// the output register fills only from a finished pose
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(eng_stat.res_valid))
		else $error("result presented without a finished pose");

endmodule

`default_nettype wire

>>> hdl/ski_ram.sv
// ----------------------------------------------------------------------------
// ski_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ski_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/ski_serial_mul.sv
// ----------------------------------------------------------------------------
// ski_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module ski_serial_mul #(
	parameter int A_W = 9,
	parameter int B_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     mcand,
	input  logic [B_W-1:0]     mplier,
	output logic               done,
	output logic [A_W+B_W-1:0] product
);

	localparam int P_W = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]   mcand_q;
	logic [B_W-1:0]   mplier_q;
	logic [P_W-1:0]   acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [P_W-1:0]   acc_next;

	assign acc_next = {acc_q[P_W-2:0], 1'b0} + (mplier_q[B_W-1] ? P_W'(mcand_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			mplier_q <= {mplier_q[B_W-2:0], 1'b0};
			acc_q    <= acc_next;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

>>> hdl/ski_serial_div.sv
// ----------------------------------------------------------------------------
// ski_serial_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ski_serial_div #(
	parameter int N_W = 20,
	parameter int D_W = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient,
	output logic [D_W-1:0] remainder
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             fits;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> hdl/ski_pose_engine.sv
// ----------------------------------------------------------------------------
// ski_pose_engine
// Walks the six joints of one pose: reads both keyframes, interpolates with a
// serial multiply and divide, clamps and maps the angle to a pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module ski_pose_engine #(
	parameter int MAX_KEYFRAMES = 8,
	localparam int ADDR_W = $clog2(MAX_KEYFRAMES * ski_pkg::JOINT_COUNT),
	localparam int SEG_W = (MAX_KEYFRAMES > 2) ? $clog2(MAX_KEYFRAMES - 1) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ski_pkg::eng_ctrl_t         ctrl,
	input  logic [SEG_W-1:0]           seg,
	input  logic [ski_pkg::STEP_W-1:0] step,
	input  logic [ski_pkg::STEP_W-1:0] steps,
	output logic [ADDR_W-1:0]          rd_addr,
	input  ski_pkg::angle_t            rd_data,
	output ski_pkg::eng_stat_t         stat,
	output ski_pkg::pulse_set_t        pulse_set
);

	localparam int IW = ski_pkg::ANGLE_W + 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_RD_A   = 9'b000000010,
		S_RD_B   = 9'b000000100,
		S_LOAD_B = 9'b000001000,
		S_MUL    = 9'b000010000,
		S_DIV1   = 9'b000100000,
		S_MAP    = 9'b001000000,
		S_DIV2   = 9'b010000000,
		S_HOLD   = 9'b100000000
	} state_t;

	state_t                           state_q;
	state_t                           state_d;
	ski_pkg::joint_t                  joint_q;
	logic [ADDR_W-1:0]                base_q;
	logic [ski_pkg::STEP_W-1:0]       step_q;
	logic [ski_pkg::STEP_W-1:0]       steps_q;
	ski_pkg::angle_t                  a_q;
	ski_pkg::angle_t                  angle_q;
	logic                             neg_q;
	ski_pkg::pulse_set_t              pulse_set_q;

	logic                             b_lt_a;
	ski_pkg::angle_t                  mag;
	logic                             mul_start;
	logic                             mul_done;
	logic [ski_pkg::PRODUCT_W-1:0]    mul_product;
	logic                             div_start;
	logic                             div_done;
	logic [ski_pkg::DIVIDEND_W-1:0]   div_dividend;
	logic [ski_pkg::DIVISOR_W-1:0]    div_divisor;
	logic [ski_pkg::DIVIDEND_W-1:0]   div_quotient;
	logic [ski_pkg::DIVISOR_W-1:0]    div_remainder;
	logic [ski_pkg::DIVIDEND_W-1:0]   scaled;
	logic [IW-1:0]                    quo_low;
	logic [IW-1:0]                    interp;
	ski_pkg::angle_t                  lo;
	ski_pkg::angle_t                  hi;
	ski_pkg::angle_t                  clamped;
	logic                             last_joint;

	// keyframe k at rows k*JOINT_COUNT, its successor one row block further
	assign rd_addr = (state_q == S_RD_A) ? base_q + ADDR_W'(joint_q)
		: base_q + ADDR_W'(ski_pkg::JOINT_COUNT) + ADDR_W'(joint_q);

	assign b_lt_a = rd_data < a_q;
	assign mag    = b_lt_a ? a_q - rd_data : rd_data - a_q;

	assign mul_start = (state_q == S_LOAD_B);
	assign div_start = ((state_q == S_MUL) && mul_done) || (state_q == S_MAP);

	assign scaled = ski_pkg::DIVIDEND_W'(angle_q) * ski_pkg::DIVIDEND_W'(ski_pkg::PULSE_SPAN);
	assign div_dividend = (state_q == S_MAP) ? scaled : ski_pkg::DIVIDEND_W'(mul_product);
	assign div_divisor = (state_q == S_MAP) ? ski_pkg::joint_range(joint_q)
		: ski_pkg::DIVISOR_W'(steps_q);

	// floor of a negative quotient rounds away from a when a remainder is left
	assign quo_low = div_quotient[IW-1:0];
	assign interp  = neg_q ? ({1'b0, a_q} - quo_low - IW'(|div_remainder))
		: ({1'b0, a_q} + quo_low);

	assign lo = ski_pkg::joint_lo(joint_q);
	assign hi = ski_pkg::joint_hi(joint_q);

	always_comb begin
		if (interp < {1'b0, lo}) begin
			clamped = lo;
		end else if (interp > {1'b0, hi}) begin
			clamped = hi;
		end else begin
			clamped = interp[IW-2:0];
		end
	end

	assign last_joint = (joint_q == ski_pkg::joint_t'(ski_pkg::JOINT_COUNT - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctrl.start) begin
					state_d = S_RD_A;
				end
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = S_LOAD_B;
			S_LOAD_B: state_d = S_MUL;
			S_MUL: begin
				if (mul_done) begin
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				if (div_done) begin
					state_d = S_MAP;
				end
			end
			S_MAP: state_d = S_DIV2;
			S_DIV2: begin
				if (div_done) begin
					state_d = last_joint ? S_HOLD : S_RD_A;
				end
			end
			S_HOLD: begin
				if (ctrl.res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			joint_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_IDLE) && ctrl.start) begin
				joint_q <= '0;
			end else if ((state_q == S_DIV2) && div_done && !last_joint) begin
				joint_q <= joint_q + ski_pkg::joint_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && ctrl.start) begin
			base_q  <= ADDR_W'(seg) * ADDR_W'(ski_pkg::JOINT_COUNT);
			step_q  <= step;
			steps_q <= steps;
		end
		if (state_q == S_RD_B) begin
			a_q <= rd_data;
		end
		if (state_q == S_LOAD_B) begin
			neg_q <= b_lt_a;
		end
		if ((state_q == S_DIV1) && div_done) begin
			angle_q <= clamped;
		end
		if ((state_q == S_DIV2) && div_done) begin
			pulse_set_q[joint_q] <= ski_pkg::PULSE_W'(ski_pkg::PULSE_MIN)
				+ div_quotient[ski_pkg::PULSE_W-1:0];
		end
	end

	ski_serial_mul #(
		.A_W(ski_pkg::ANGLE_W),
		.B_W(ski_pkg::STEP_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mag),
		.mplier (step_q),
		.done   (mul_done),
		.product(mul_product)
	);

	ski_serial_div #(
		.N_W(ski_pkg::DIVIDEND_W),
		.D_W(ski_pkg::DIVISOR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient),
		.remainder(div_remainder)
	);

	assign stat.busy      = (state_q != S_IDLE);
	assign stat.res_valid = (state_q == S_HOLD);
	assign pulse_set      = pulse_set_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the servo keyframe interpolator core against a shadow copy of its
// table, run state and registers: loads, starts, ticks and ignored items go
// in over the item channel, and every pose leaving the result channel is
// compared field by field. Items idle and results stall at random.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYFRAMES = 8;
	localparam int SETTLE_CYCLES = 400;
	localparam int ITEM_TARGET = 400;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		ski_pkg::pulse_set_t pulse;
		logic [2:0] seg;
		logic done;
	} pose_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  opcode;
	logic [2:0]  frame_index;
	logic [2:0]  joint_index;
	logic [8:0]  angle_value;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [11:0] gripper_pulse;
	logic [11:0] base_pulse;
	logic [11:0] shoulder_pulse;
	logic [11:0] elbow_pulse;
	logic [11:0] pitch_pulse;
	logic [11:0] roll_pulse;
	logic [2:0]  segment_number;
	logic        run_done;

	// shadow of the sequencer
	ski_pkg::angle_t keyframe_mem [KEYFRAMES][ski_pkg::JOINT_COUNT];
	bit         keyframe_set [KEYFRAMES][ski_pkg::JOINT_COUNT];
	bit         run_active = 1'b0;
	int         seg_pos = 0;
	int         step_pos = 0;
	logic [7:0] steps_reg = 8'd60;
	logic [3:0] count_reg = 4'd6;

	int limit_lo [ski_pkg::JOINT_COUNT] = '{0, 10, 20, 20, 10, 10};
	int limit_hi [ski_pkg::JOINT_COUNT] = '{180, 260, 160, 160, 170, 170};
	string joint_name [ski_pkg::JOINT_COUNT] = '{"gripper", "base", "shoulder", "elbow",
		"pitch", "roll"};

	pose_t pending_poses [$];
	int    mismatch_count = 0;
	int    poses_checked = 0;
	int    items_sent = 0;
	int    items_effective = 0;
	int    runs_finished = 0;
	int    stall_left = 0;
	bit    quiet_mode = 1'b0;

	servo_keyframe_interpolator_core #(
		.MAX_KEYFRAMES(KEYFRAMES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.frame_index(frame_index),
		.joint_index(joint_index),
		.angle_value(angle_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.gripper_pulse(gripper_pulse),
		.base_pulse(base_pulse),
		.shoulder_pulse(shoulder_pulse),
		.elbow_pulse(elbow_pulse),
		.pitch_pulse(pitch_pulse),
		.roll_pulse(roll_pulse),
		.segment_number(segment_number),
		.run_done(run_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// updates the shadow for one accepted transaction and queues its pose
	function automatic void advance_shadow(input logic [1:0] op, input logic [2:0] fr,
			input logic [2:0] jt, input logic [8:0] ang);
		int n, cnt, i, s, a, b, num, q, v, range;
		pose_t want;
		case (op)
			ski_pkg::OP_LOAD: begin
				if (jt < ski_pkg::JOINT_COUNT) begin
					keyframe_mem[fr][jt] = ang;
					keyframe_set[fr][jt] = 1'b1;
					items_effective++;
				end
			end
			ski_pkg::OP_START: begin
				if (!run_active) begin
					run_active = 1'b1;
					seg_pos = 0;
					step_pos = 0;
					items_effective++;
				end
			end
			ski_pkg::OP_TICK: begin
				if (run_active) begin
					items_effective++;
					n = (steps_reg == 0) ? 1 : int'(steps_reg);
					cnt = int'(count_reg);
					if (cnt < 2)
						cnt = 2;
					if (cnt > KEYFRAMES)
						cnt = KEYFRAMES;
					i = (step_pos > n) ? n : step_pos;
					s = (seg_pos > KEYFRAMES - 2) ? KEYFRAMES - 2 : seg_pos;
					for (int j = 0; j < ski_pkg::JOINT_COUNT; j++) begin
						a = int'(keyframe_mem[s][j]);
						b = int'(keyframe_mem[s + 1][j]);
						num = (b - a) * i;
						q = num / n;
						// round toward minus infinity on a falling segment
						if ((num % n) != 0 && num < 0)
							q--;
						v = a + q;
						if (v < limit_lo[j])
							v = limit_lo[j];
						if (v > limit_hi[j])
							v = limit_hi[j];
						range = (j == ski_pkg::JOINT_BASE) ? ski_pkg::BASE_RANGE
							: ski_pkg::STD_RANGE;
						want.pulse[j] = ski_pkg::PULSE_W'(ski_pkg::PULSE_MIN
							+ v * ski_pkg::PULSE_SPAN / range);
					end
					want.seg = 3'(seg_pos);
					want.done = 1'b0;
					if (step_pos >= n) begin
						if (seg_pos + 1 >= cnt - 1) begin
							want.done = 1'b1;
							run_active = 1'b0;
							seg_pos = 0;
							step_pos = 0;
						end else begin
							seg_pos++;
							step_pos = 0;
						end
					end else begin
						step_pos++;
					end
					pending_poses.push_back(want);
				end
			end
			default: ;
		endcase
	endfunction

	// entered and left at a falling edge; valid stays up when no gap follows
	task automatic send_item(input logic [1:0] op, input logic [2:0] fr,
			input logic [2:0] jt, input logic [8:0] ang);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		frame_index <= fr;
		joint_index <= jt;
		angle_value <= ang;
		do
			@(posedge clk);
		while (item_stall);
		advance_shadow(op, fr, jt, ang);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [8:0] rand_angle();
		return ($urandom_range(0, 9) == 0) ? 9'($urandom_range(271, 511))
			: 9'($urandom_range(0, 270));
	endfunction

	task automatic send_noise();
		if ($urandom_range(0, 1) == 1)
			send_item(OP_UNUSED, 3'($urandom), 3'($urandom), 9'($urandom));
		else
			send_item(ski_pkg::OP_LOAD, 3'($urandom), 3'($urandom_range(6, 7)),
				rand_angle());
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == ski_pkg::REG_SEGMENT_STEPS)
			steps_reg = value[7:0];
		else
			count_reg = value[3:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, wait for every pose, then let stray work finish
	task automatic settle_idle();
		item_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one setting: fill the frames in use, start, tick to the end of the run
	task automatic run_sequence(input int steps_val, input int count_val);
		int eff, pick;
		settle_idle();
		write_reg(ski_pkg::REG_SEGMENT_STEPS, 32'(steps_val));
		write_reg(ski_pkg::REG_KEYFRAME_COUNT, 32'(count_val));
		quiet_mode = ($urandom_range(0, 3) == 0);
		eff = (count_val < 2) ? 2 : (count_val > KEYFRAMES) ? KEYFRAMES : count_val;
		for (int f = 0; f < eff; f++) begin
			for (int j = 0; j < ski_pkg::JOINT_COUNT; j++) begin
				if (!keyframe_set[f][j] || $urandom_range(0, 2) == 0)
					send_item(ski_pkg::OP_LOAD, 3'(f), 3'(j), rand_angle());
				if ($urandom_range(0, 15) == 0)
					send_noise();
			end
		end
		send_item(ski_pkg::OP_START, 3'($urandom), 3'($urandom), 9'($urandom));
		while (run_active) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)
				send_item(ski_pkg::OP_TICK, 3'($urandom), 3'($urandom), 9'($urandom));
			else if (pick < 17)
				send_item(ski_pkg::OP_LOAD, 3'($urandom), 3'($urandom), rand_angle());
			else if (pick == 17)
				send_item(ski_pkg::OP_START, 3'($urandom), 3'($urandom), 9'($urandom));
			else
				send_noise();
		end
		send_item(ski_pkg::OP_TICK, 3'($urandom), 3'($urandom), 9'($urandom));
		send_noise();
		runs_finished++;
	endtask

	task automatic test_directed_corners();
		write_reg(ski_pkg::REG_SEGMENT_STEPS, 32'd1);
		write_reg(ski_pkg::REG_KEYFRAME_COUNT, 32'd2);
		// tick and unused opcode with nothing running
		send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
		send_item(OP_UNUSED, 3'd7, 3'd7, 9'd511);
		// angles at and beyond the joint limits
		send_item(ski_pkg::OP_LOAD, 3'd0, ski_pkg::JOINT_GRIPPER, 9'd0);
		send_item(ski_pkg::OP_LOAD, 3'd0, ski_pkg::JOINT_BASE, 9'd0);
		send_item(ski_pkg::OP_LOAD, 3'd0, ski_pkg::JOINT_SHOULDER, 9'd511);
		send_item(ski_pkg::OP_LOAD, 3'd0, ski_pkg::JOINT_ELBOW, 9'd270);
		send_item(ski_pkg::OP_LOAD, 3'd0, ski_pkg::JOINT_PITCH, 9'd5);
		send_item(ski_pkg::OP_LOAD, 3'd0, ski_pkg::JOINT_ROLL, 9'd180);
		send_item(ski_pkg::OP_LOAD, 3'd1, ski_pkg::JOINT_GRIPPER, 9'd180);
		send_item(ski_pkg::OP_LOAD, 3'd1, ski_pkg::JOINT_BASE, 9'd270);
		send_item(ski_pkg::OP_LOAD, 3'd1, ski_pkg::JOINT_SHOULDER, 9'd0);
		send_item(ski_pkg::OP_LOAD, 3'd1, ski_pkg::JOINT_ELBOW, 9'd100);
		send_item(ski_pkg::OP_LOAD, 3'd1, ski_pkg::JOINT_PITCH, 9'd511);
		send_item(ski_pkg::OP_LOAD, 3'd1, ski_pkg::JOINT_ROLL, 9'd9);
		// joint index past the last joint is dropped
		send_item(ski_pkg::OP_LOAD, 3'd7, 3'd6, 9'd511);
		send_item(ski_pkg::OP_START, 3'd0, 3'd0, 9'd0);
		// second start while running is dropped
		send_item(ski_pkg::OP_START, 3'd0, 3'd0, 9'd0);
		send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
		send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
		send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
	endtask

	task automatic test_register_extremes();
		run_sequence(0, 0);
		run_sequence(1, 8);
		run_sequence(2, 15);
		run_sequence(1, 1);
		run_sequence(4, 9);
	endtask

	// long segment cut short, then keyframe count dropped under the segment
	task automatic test_register_change_mid_run();
		settle_idle();
		write_reg(ski_pkg::REG_SEGMENT_STEPS, 32'd255);
		write_reg(ski_pkg::REG_KEYFRAME_COUNT, 32'd3);
		for (int f = 0; f < 3; f++) begin
			for (int j = 0; j < ski_pkg::JOINT_COUNT; j++) begin
				send_item(ski_pkg::OP_LOAD, 3'(f), 3'(j), rand_angle());
			end
		end
		send_item(ski_pkg::OP_START, 3'd0, 3'd0, 9'd0);
		repeat (6) send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
		settle_idle();
		// step already past the new step count
		write_reg(ski_pkg::REG_SEGMENT_STEPS, 32'd3);
		repeat (2) send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
		settle_idle();
		write_reg(ski_pkg::REG_KEYFRAME_COUNT, 32'd2);
		while (run_active)
			send_item(ski_pkg::OP_TICK, 3'd0, 3'd0, 9'd0);
		runs_finished++;
	endtask

	task automatic test_random_sequences();
		while (items_sent < ITEM_TARGET) begin
			run_sequence(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
				: $urandom_range(0, 6), $urandom_range(0, 15));
		end
	endtask

	always @(posedge clk) begin : pose_check
		pose_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got.pulse[ski_pkg::JOINT_GRIPPER] = gripper_pulse;
			got.pulse[ski_pkg::JOINT_BASE] = base_pulse;
			got.pulse[ski_pkg::JOINT_SHOULDER] = shoulder_pulse;
			got.pulse[ski_pkg::JOINT_ELBOW] = elbow_pulse;
			got.pulse[ski_pkg::JOINT_PITCH] = pitch_pulse;
			got.pulse[ski_pkg::JOINT_ROLL] = roll_pulse;
			got.seg = segment_number;
			got.done = run_done;
			if (pending_poses.size() == 0) begin
				report_mismatch("pose transaction with none outstanding");
			end else begin
				want = pending_poses.pop_front();
				for (int j = 0; j < ski_pkg::JOINT_COUNT; j++) begin
					if (got.pulse[j] !== want.pulse[j])
						report_mismatch($sformatf("%s pulse %0d, want %0d",
							joint_name[j], got.pulse[j], want.pulse[j]));
				end
				if (got.seg !== want.seg)
					report_mismatch($sformatf("segment_number %0d, want %0d",
						got.seg, want.seg));
				if (got.done !== want.done)
					report_mismatch($sformatf("run_done %0b, want %0b",
						got.done, want.done));
			end
			poses_checked++;
			stall_left = quiet_mode ? 0 : $urandom_range(0, 7);
		end
	end

	// stall count only runs down while a pose is waiting
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			if (result_valid)
				stall_left = stall_left - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		item_valid = 1'b0;
		opcode = ski_pkg::OP_LOAD;
		frame_index = 3'd0;
		joint_index = 3'd0;
		angle_value = 9'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_corners();
		test_register_extremes();
		test_register_change_mid_run();
		test_random_sequences();
		settle_idle();
		$display("Sent %0d items (%0d took effect), checked %0d poses over %0d runs",
			items_sent, items_effective, poses_checked, runs_finished + 1);
		$display("Step settings 0 to 255 and keyframe counts 0 to 15 were exercised");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout after 20 ms of simulated time");
		$display("Mismatches found");
		$finish;
	end

endmodule
